### sv/rfid_reply_frame_receiver_macros.svh
// Assertion macros used by the checker file of the reply frame receiver.
`ifndef RFID_REPLY_FRAME_RECEIVER_MACROS_SVH
`define RFID_REPLY_FRAME_RECEIVER_MACROS_SVH

// Checked on every rising edge outside reset.
`define RFRX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define RFRX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/rfrx_pkg.sv
// Types, codes and constants of the reply frame receiver.
package rfrx_pkg;

  localparam logic [7:0] HEAD_CODE_RST    = 8'hBB;
  localparam logic [7:0] END_CODE_RST     = 8'h7E;
  localparam logic [7:0] LENGTH_LIMIT_RST = 8'd100;
  localparam logic [7:0] NO_TAG_RST       = 8'd21;

  localparam logic [7:0] ALL_ONES_BYTE = 8'hFF;
  localparam logic [7:0] MAX_POSITION  = 8'd255;
  localparam logic [7:0] MIN_FRAME_LEN = 8'd7;
  localparam logic [7:0] POS_SECOND    = 8'd2;
  localparam logic [7:0] POS_FIFTH     = 8'd5;

  typedef enum logic [1:0] {
    CFG_HEAD_CODE,
    CFG_END_CODE,
    CFG_LENGTH_LIMIT,
    CFG_NO_TAG_VALUE
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_TAG,
    ST_NO_TAG,
    ST_BAD_SUM,
    ST_TOO_LONG,
    ST_ABORTED
  } status_t;

  typedef enum logic {
    OP_BYTE,
    OP_RESTART
  } opcode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        frame_byte;
    logic [7:0]        position;
    logic              last;
    status_t           status;
    logic signed [7:0] rssi;
  } out_item_t;

  typedef struct packed {
    logic [7:0] head_code;
    logic [7:0] end_code;
    logic [7:0] length_limit;
    logic [7:0] no_tag_value;
  } cfg_t;

  typedef struct packed {
    logic       in_frame;
    logic [7:0] byte_count;
    logic [7:0] running_sum;
    logic [7:0] previous_byte;
    logic       second_ff;
    logic [7:0] fifth_byte;
  } frame_t;

endpackage

### sv/rfid_reply_frame_receiver.sv
// Top level of the reply frame receiver: configuration registers, input register, deframer and result register.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_data   (in_item_t)
//   out_     output     out_valid / out_ready  out_data  (out_item_t)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request is taken per cycle unless a stalled result has the input register full;
// a request passes the input register, the deframer's combinational logic and the result
// register. Reset is synchronous and clears the frame state and the valid flags, and sets
// the configuration registers to their reset values. A stalled result holds the result
// register; the input register still takes one request while it waits. cfg_ready is always high.
module rfid_reply_frame_receiver
  import rfrx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_free;
  logic      step;
  logic      res_valid;
  out_item_t res;
  cfg_t      cfg;

  assign out_free  = !out_valid_r || out_ready;
  assign step      = in_valid_r && out_free;
  assign in_ready  = !in_valid_r || out_free;
  assign cfg_ready = 1'b1;

  rfrx_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rfrx_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (in_data_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/rfrx_cfg_regs.sv
// Configuration register file of the reply frame receiver.
module rfrx_cfg_regs
  import rfrx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        CFG_HEAD_CODE:    cfg_nxt.head_code    = wr_data;
        CFG_END_CODE:     cfg_nxt.end_code     = wr_data;
        CFG_LENGTH_LIMIT: cfg_nxt.length_limit = wr_data;
        CFG_NO_TAG_VALUE: cfg_nxt.no_tag_value = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_code    <= HEAD_CODE_RST;
      cfg_r.end_code     <= END_CODE_RST;
      cfg_r.length_limit <= LENGTH_LIMIT_RST;
      cfg_r.no_tag_value <= NO_TAG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/rfrx_deframer.sv
// Frame state and per-byte deframing logic of the reply frame receiver.
module rfrx_deframer
  import rfrx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_item_t res
);

  frame_t     frame_r;
  frame_t     frame_nxt;
  logic [7:0] pos;
  logic [7:0] check_sum;
  logic       is_end;
  logic       too_long;

  assign pos       = frame_r.byte_count;
  // Sum over the bytes after the head, less the checksum byte held last.
  assign check_sum = frame_r.running_sum - frame_r.previous_byte;
  assign is_end    = (item.rx_byte == cfg.end_code) && (pos >= (MIN_FRAME_LEN - 8'd1));
  // The length after this byte would exceed the limit, or the position would wrap.
  assign too_long  = (pos >= cfg.length_limit) || (pos == MAX_POSITION);

  always_comb begin
    frame_nxt = frame_r;
    res_valid = 1'b0;
    res       = '0;
    if (step) begin
      if (item.opcode == OP_RESTART) begin
        frame_nxt    = '0;
        res_valid    = frame_r.in_frame;
        res.position = pos;
        res.last     = 1'b1;
        res.status   = ST_ABORTED;
      end else if (!frame_r.in_frame) begin
        if (item.rx_byte == cfg.head_code) begin
          frame_nxt            = '0;
          frame_nxt.in_frame   = 1'b1;
          frame_nxt.byte_count = 8'd1;
          res_valid            = 1'b1;
          res.frame_byte       = item.rx_byte;
        end
      end else begin
        res_valid      = 1'b1;
        res.frame_byte = item.rx_byte;
        res.position   = pos;
        if (is_end) begin
          frame_nxt = '0;
          res.last  = 1'b1;
          if (check_sum == frame_r.previous_byte) begin
            res.status = (frame_r.second_ff && (frame_r.fifth_byte == cfg.no_tag_value)) ?
                         ST_NO_TAG : ST_TAG;
            res.rssi   = $signed(frame_r.fifth_byte);
          end else begin
            res.status = ST_BAD_SUM;
          end
        end else if (too_long) begin
          frame_nxt  = '0;
          res.last   = 1'b1;
          res.status = ST_TOO_LONG;
        end else begin
          frame_nxt.running_sum   = frame_r.running_sum + item.rx_byte;
          frame_nxt.previous_byte = item.rx_byte;
          frame_nxt.byte_count    = pos + 8'd1;
          if (pos == POS_SECOND) begin
            frame_nxt.second_ff = (item.rx_byte == ALL_ONES_BYTE);
          end
          if (pos == POS_FIFTH) begin
            frame_nxt.fifth_byte = item.rx_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else begin
      frame_r <= frame_nxt;
    end
  end

endmodule

### sv/rfrx_checker.sv
// Port-level assertions of the reply frame receiver and their bind.
`include "rfid_reply_frame_receiver_macros.svh"

module rfrx_checker
  import rfrx_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input out_item_t  out_data
);

  logic stalled;
  logic head_out;
  logic mid_out;
  logic mid_clean;
  logic err_out;

  assign stalled   = out_valid && !out_ready;
  assign head_out  = out_valid && (out_data.position == 8'd0);
  assign mid_out   = out_valid && !out_data.last;
  assign mid_clean = (out_data.status == ST_TAG) && (out_data.rssi == 8'sd0);
  assign err_out   = out_valid && ((out_data.status == ST_BAD_SUM) ||
                                   (out_data.status == ST_TOO_LONG) ||
                                   (out_data.status == ST_ABORTED));

  // A stalled result keeps its place and its contents.
  `RFRX_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_data), "stalled result changed")

  // Nothing is offered in the cycle after reset.
  `RFRX_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result offered after reset")

  // The head byte never closes a frame.
  `RFRX_ASSERT(a_head_open, head_out |-> !out_data.last, "frame closed at position zero")

  // A byte inside the frame carries no status and no RSSI.
  `RFRX_ASSERT(a_mid_clean, mid_out |-> mid_clean, "status or rssi on a non-final byte")

  // Error closes carry no RSSI.
  `RFRX_ASSERT(a_err_rssi, err_out |-> (out_data.rssi == 8'sd0), "rssi on an error close")

endmodule

bind rfid_reply_frame_receiver rfrx_checker u_rfrx_checker (.*);
